[rtl/core/debug_run_control_breakpoints_defines.svh]
// Assertion macros for the debug run-control block.
`ifndef DEBUG_RUN_CONTROL_BREAKPOINTS_DEFINES_SVH
`define DEBUG_RUN_CONTROL_BREAKPOINTS_DEFINES_SVH

// Checked at every edge, reset included.
`define DRCB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only outside reset.
`define DRCB_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

[rtl/core/drcb_pkg.sv]
// Types and constants shared by the debug run-control block.
package drcb_pkg;

  localparam int BREAKPOINT_SLOTS_DEF = 16;
  localparam int LINE_BITS_DEF        = 16;
  localparam int FIELD_LINE_BITS      = 16;

  typedef enum logic [2:0] {
    OP_CHECK  = 3'd0,
    OP_START  = 3'd1,
    OP_STEP   = 3'd2,
    OP_PAUSE  = 3'd3,
    OP_RESUME = 3'd4,
    OP_STOP   = 3'd5,
    OP_CLEAR  = 3'd6,
    OP_TOGGLE = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    DEC_PROCEED = 2'd0,
    DEC_WAIT    = 2'd1,
    DEC_STOPPED = 2'd2,
    DEC_COMMAND = 2'd3
  } decision_t;

  typedef enum logic [1:0] {
    TGL_ADDED   = 2'd0,
    TGL_REMOVED = 2'd1,
    TGL_FULL    = 2'd2,
    TGL_NONE    = 2'd3
  } toggle_t;

  // Run mode, one-hot.
  typedef enum logic [3:0] {
    MODE_RUN   = 4'b0001,
    MODE_STEP  = 4'b0010,
    MODE_PAUSE = 4'b0100,
    MODE_STOP  = 4'b1000
  } mode_t;

  typedef struct packed {
    op_t                        operation;
    logic [FIELD_LINE_BITS-1:0] line_number;
  } req_t;

  typedef struct packed {
    decision_t                  decision;
    logic                       pause_notice;
    logic                       stop_notice;
    logic [FIELD_LINE_BITS-1:0] notice_line;
    toggle_t                    toggle_outcome;
  } rsp_t;

endpackage

[rtl/core/debug_run_control_breakpoints.sv]
// Debug run-control unit: line checks, run commands and a breakpoint table.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-----------------------------------
//   req     | in  | req_valid/req_stall  | req_data : operation, line_number
//   rsp     | out | rsp_valid/rsp_stall  | rsp_data : decision, notices, toggle
//   cfg     | in  | cfg_valid/cfg_ready  | cfg_data : notifier_attached
//
// One request per cycle sustained while the response is not stalled; each request
// passes the input register, then the response register, from accept to response.
// The table compare and the lowest-free-slot pick run combinationally
// between the two registers; run state updates as a request leaves the
// input register.
// Reset sets mode to run and sets step_consumed, and clears the other flags and
// all breakpoint valid bits; no clearing pass. cfg_ready is always high.
// A stalled response holds the input register; req_stall rises only then.
`include "debug_run_control_breakpoints_defines.svh"

module debug_run_control_breakpoints #(
  parameter int BREAKPOINT_SLOTS = drcb_pkg::BREAKPOINT_SLOTS_DEF,
  parameter int LINE_BITS        = drcb_pkg::LINE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  drcb_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output drcb_pkg::rsp_t rsp_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data
);

  // Input register
  logic           in_valid;
  drcb_pkg::req_t in_req;

  // Run-control state
  drcb_pkg::mode_t mode, mode_next;
  logic            step_consumed, step_consumed_next;
  logic            wait_noticed, wait_noticed_next;
  logic            notifier_attached;

  // Breakpoint table: valid bits reset, lines are payload only
  logic [BREAKPOINT_SLOTS-1:0] bp_valid, bp_valid_next;
  logic [LINE_BITS-1:0]        bp_line [BREAKPOINT_SLOTS];

  logic                        advance;
  logic                        accept;
  logic [LINE_BITS-1:0]        line_key;
  logic [BREAKPOINT_SLOTS-1:0] slot_hit;
  logic [BREAKPOINT_SLOTS-1:0] free_slots;
  logic [BREAKPOINT_SLOTS-1:0] free_lowest;
  logic                        hit;
  logic                        do_add;
  drcb_pkg::rsp_t              rsp_next;

  assign cfg_ready = 1'b1;

  // The input register drains whenever the response register is free or emptying.
  assign advance   = in_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = in_valid && !advance;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept || (in_valid && !advance);
    end
    if (accept) begin
      in_req <= req_data;
    end
  end

  // Line taken in its low LINE_BITS bits
  assign line_key = LINE_BITS'(in_req.line_number);

  // Parallel compare against every slot
  always_comb begin
    for (int k = 0; k < BREAKPOINT_SLOTS; k++) begin
      slot_hit[k] = bp_valid[k] && (bp_line[k] == line_key);
    end
  end

  assign hit         = |slot_hit;
  assign free_slots  = ~bp_valid;
  assign free_lowest = free_slots & (~free_slots + BREAKPOINT_SLOTS'(1));

  always_comb begin
    mode_next          = mode;
    step_consumed_next = step_consumed;
    wait_noticed_next  = wait_noticed;
    bp_valid_next      = bp_valid;
    do_add             = 1'b0;
    rsp_next           = '{decision:       drcb_pkg::DEC_COMMAND,
                           pause_notice:   1'b0,
                           stop_notice:    1'b0,
                           notice_line:    '0,
                           toggle_outcome: drcb_pkg::TGL_NONE};

    unique case (in_req.operation)
      drcb_pkg::OP_CHECK: begin
        if (mode == drcb_pkg::MODE_STOP) begin
          rsp_next.decision = drcb_pkg::DEC_STOPPED;
        end else if ((mode == drcb_pkg::MODE_RUN || mode == drcb_pkg::MODE_STEP)
                     && !step_consumed) begin
          // pending step: go without looking at the table
          step_consumed_next = 1'b1;
          rsp_next.decision  = drcb_pkg::DEC_PROCEED;
        end else if (mode == drcb_pkg::MODE_RUN && !hit) begin
          rsp_next.decision = drcb_pkg::DEC_PROCEED;
        end else begin
          rsp_next.decision = drcb_pkg::DEC_WAIT;
        end

        if (rsp_next.decision == drcb_pkg::DEC_STOPPED) begin
          wait_noticed_next = 1'b0;
          if (notifier_attached) begin
            rsp_next.stop_notice = 1'b1;
            rsp_next.notice_line = drcb_pkg::FIELD_LINE_BITS'(line_key);
          end
        end else if (rsp_next.decision == drcb_pkg::DEC_WAIT) begin
          // only the first wait of an episode is announced
          if (!wait_noticed) begin
            wait_noticed_next = 1'b1;
            if (notifier_attached) begin
              rsp_next.pause_notice = 1'b1;
              rsp_next.notice_line  = drcb_pkg::FIELD_LINE_BITS'(line_key);
            end
          end
        end else begin
          wait_noticed_next = 1'b0;
        end
      end
      drcb_pkg::OP_START: begin
        mode_next          = drcb_pkg::MODE_RUN;
        step_consumed_next = 1'b1;
      end
      drcb_pkg::OP_STEP: begin
        mode_next          = drcb_pkg::MODE_STEP;
        step_consumed_next = 1'b0;
      end
      drcb_pkg::OP_PAUSE: begin
        mode_next = drcb_pkg::MODE_PAUSE;
      end
      drcb_pkg::OP_RESUME: begin
        mode_next          = drcb_pkg::MODE_RUN;
        step_consumed_next = 1'b0;
      end
      drcb_pkg::OP_STOP: begin
        mode_next = drcb_pkg::MODE_STOP;
      end
      drcb_pkg::OP_CLEAR: begin
        bp_valid_next = '0;
      end
      drcb_pkg::OP_TOGGLE: begin
        if (hit) begin
          // a line sits in at most one slot
          bp_valid_next           = bp_valid & ~slot_hit;
          rsp_next.toggle_outcome = drcb_pkg::TGL_REMOVED;
        end else if (|free_slots) begin
          bp_valid_next           = bp_valid | free_lowest;
          do_add                  = 1'b1;
          rsp_next.toggle_outcome = drcb_pkg::TGL_ADDED;
        end else begin
          rsp_next.toggle_outcome = drcb_pkg::TGL_FULL;
        end
      end
      default: begin
        rsp_next.decision = drcb_pkg::DEC_COMMAND;
      end
    endcase
  end

  // State and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= drcb_pkg::MODE_RUN;
      step_consumed     <= 1'b1;
      wait_noticed      <= 1'b0;
      bp_valid          <= '0;
      notifier_attached <= 1'b0;
      rsp_valid         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        notifier_attached <= cfg_data;
      end
      if (advance) begin
        mode          <= mode_next;
        step_consumed <= step_consumed_next;
        wait_noticed  <= wait_noticed_next;
        bp_valid      <= bp_valid_next;
        rsp_valid     <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    if (advance) begin
      rsp_data <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < BREAKPOINT_SLOTS; k++) begin
      if (advance && do_add && free_lowest[k]) begin
        bp_line[k] <= line_key;
      end
    end
  end

  // Checks
  `DRCB_ASSERT_ALWAYS(a_reset_empties_table, rst |=> (bp_valid == '0), "table not empty after reset")
  `DRCB_ASSERT_RUN(a_pause_notice_wait, (rsp_valid && rsp_data.pause_notice) |-> (rsp_data.decision == drcb_pkg::DEC_WAIT && !rsp_data.stop_notice), "pause notice without wait")
  `DRCB_ASSERT_RUN(a_add_grows_table, (advance && do_add) |=> ($countones(bp_valid) == $countones($past(bp_valid)) + 1), "toggle add did not fill one slot")
  `DRCB_ASSERT_RUN(a_toggle_only_on_toggle, (rsp_valid && rsp_data.decision != drcb_pkg::DEC_COMMAND) |-> (rsp_data.toggle_outcome == drcb_pkg::TGL_NONE), "toggle outcome on a check")

endmodule

[test/tb.sv]
// Self-checking testbench for the debug run-control block and its breakpoint table.
`timescale 1ns / 1ps

module tb;

  localparam int SLOTS        = drcb_pkg::BREAKPOINT_SLOTS_DEF;
  localparam int LW           = drcb_pkg::FIELD_LINE_BITS;
  localparam int POOL_SIZE    = 20;
  localparam int PHASE_ITEMS  = 225;
  localparam int RUN_LIMIT_NS = 5_000_000;

  // Clock and reset; every block input starts at a known value.
  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  drcb_pkg::req_t req_data  = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  drcb_pkg::rsp_t rsp_data;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic           cfg_data  = 1'b0;

  always #5 clk = ~clk;

  debug_run_control_breakpoints DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Idle/stall odds in percent, changed between phases.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  // Counters and the queue of answers still owed by the block.
  int             fail_count     = 0;
  int             responses_seen = 0;
  int             requests_sent  = 0;
  drcb_pkg::rsp_t answers_owed[$];
  drcb_pkg::rsp_t oldest_answer;
  drcb_pkg::rsp_t predicted_answer;

  // Lines reused often so that checks hit breakpoints and toggles remove them.
  logic [LW-1:0] line_pool [POOL_SIZE];

  // ---------------------------------------------------------------------------
  // Mirror of the block's run state and breakpoint table.
  // ---------------------------------------------------------------------------
  logic             notify_on;
  drcb_pkg::mode_t  run_state;
  logic             step_used;    // single step already spent
  logic             wait_seen;    // current waiting episode already announced
  logic [SLOTS-1:0] bp_valid;
  logic [LW-1:0]    bp_line [SLOTS];

  // Works out the answer to one request and advances the mirror state.
  function automatic drcb_pkg::rsp_t predict_answer(input drcb_pkg::req_t r);
    drcb_pkg::rsp_t a;
    int             hit_slot;
    int             free_slot;
    a.decision       = drcb_pkg::DEC_COMMAND;
    a.pause_notice   = 1'b0;
    a.stop_notice    = 1'b0;
    a.notice_line    = '0;
    a.toggle_outcome = drcb_pkg::TGL_NONE;
    hit_slot  = -1;
    free_slot = -1;
    // Parallel compare; the table never holds a line twice.
    for (int k = 0; k < SLOTS; k++) begin
      if (bp_valid[k] && bp_line[k] == r.line_number && hit_slot < 0) hit_slot = k;
      if (!bp_valid[k] && free_slot < 0) free_slot = k;
    end
    case (r.operation)
      drcb_pkg::OP_CHECK: begin
        if (run_state == drcb_pkg::MODE_STOP) begin
          a.decision = drcb_pkg::DEC_STOPPED;
        end else if ((run_state == drcb_pkg::MODE_RUN || run_state == drcb_pkg::MODE_STEP)
                     && !step_used) begin
          // pending step: consumed, table not consulted
          step_used  = 1'b1;
          a.decision = drcb_pkg::DEC_PROCEED;
        end else if (run_state == drcb_pkg::MODE_RUN && hit_slot < 0) begin
          a.decision = drcb_pkg::DEC_PROCEED;
        end else begin
          a.decision = drcb_pkg::DEC_WAIT;
        end
        if (a.decision == drcb_pkg::DEC_STOPPED) begin
          wait_seen = 1'b0;
          if (notify_on) begin
            a.stop_notice = 1'b1;
            a.notice_line = r.line_number;
          end
        end else if (a.decision == drcb_pkg::DEC_WAIT) begin
          // only the first wait of an episode is announced
          if (!wait_seen) begin
            wait_seen = 1'b1;
            if (notify_on) begin
              a.pause_notice = 1'b1;
              a.notice_line  = r.line_number;
            end
          end
        end else begin
          wait_seen = 1'b0;
        end
      end
      drcb_pkg::OP_START: begin
        run_state = drcb_pkg::MODE_RUN;
        step_used = 1'b1;
      end
      drcb_pkg::OP_STEP: begin
        run_state = drcb_pkg::MODE_STEP;
        step_used = 1'b0;
      end
      drcb_pkg::OP_PAUSE:  run_state = drcb_pkg::MODE_PAUSE;
      drcb_pkg::OP_RESUME: begin
        run_state = drcb_pkg::MODE_RUN;
        step_used = 1'b0;
      end
      drcb_pkg::OP_STOP:  run_state = drcb_pkg::MODE_STOP;
      drcb_pkg::OP_CLEAR: bp_valid  = '0;
      drcb_pkg::OP_TOGGLE: begin
        if (hit_slot >= 0) begin
          bp_valid[hit_slot] = 1'b0;
          a.toggle_outcome   = drcb_pkg::TGL_REMOVED;
        end else if (free_slot >= 0) begin
          // new line lands in the lowest free slot
          bp_valid[free_slot] = 1'b1;
          bp_line[free_slot]  = r.line_number;
          a.toggle_outcome    = drcb_pkg::TGL_ADDED;
        end else begin
          a.toggle_outcome = drcb_pkg::TGL_FULL;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: sampled at the rising edge. Responses are checked before the
  // request of the same edge is predicted, so a response can never be matched
  // against an answer owed for a request taken in that very cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      notify_on = 1'b0;
      run_state = drcb_pkg::MODE_RUN;
      step_used = 1'b1;
      wait_seen = 1'b0;
      bp_valid  = '0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        responses_seen++;
        if (answers_owed.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("response %0d with no request outstanding: %p",
                     responses_seen, rsp_data);
        end else begin
          oldest_answer = answers_owed.pop_front();
          if (rsp_data.decision       !== oldest_answer.decision     ||
              rsp_data.pause_notice   !== oldest_answer.pause_notice ||
              rsp_data.stop_notice    !== oldest_answer.stop_notice  ||
              rsp_data.notice_line    !== oldest_answer.notice_line  ||
              rsp_data.toggle_outcome !== oldest_answer.toggle_outcome) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"response %0d: expected dec=%0d pause=%0b stop=%0b line=%h tgl=%0d,",
                        " got dec=%0d pause=%0b stop=%0b line=%h tgl=%0d"},
                       responses_seen, oldest_answer.decision, oldest_answer.pause_notice,
                       oldest_answer.stop_notice, oldest_answer.notice_line,
                       oldest_answer.toggle_outcome, rsp_data.decision,
                       rsp_data.pause_notice, rsp_data.stop_notice,
                       rsp_data.notice_line, rsp_data.toggle_outcome);
          end
        end
      end
      if (cfg_valid && cfg_ready) notify_on = cfg_data;
      if (req_valid && !req_stall) begin
        predicted_answer = predict_answer(req_data);
        answers_owed     = {answers_owed, predicted_answer};
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    if (!rst) rsp_stall = ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Presents one request at a falling edge, holds it until the block takes it.
  task automatic send_request(input drcb_pkg::op_t op, input logic [LW-1:0] line);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid             = 1'b1;
    req_data.operation    = op;
    req_data.line_number  = line;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    requests_sent++;
  endtask

  // Stops sending and waits for every owed response.
  task automatic drain_requests();
    @(negedge clk);
    req_valid = 1'b0;
    while (answers_owed.size() != 0) @(posedge clk);
  endtask

  // Notifier register write; only ever done with the block idle.
  task automatic set_notifier(input logic attach);
    drain_requests();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = attach;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [LW-1:0] pick_line();
    if ($urandom_range(9) == 0) return LW'($urandom);
    return line_pool[$urandom_range(POOL_SIZE-1)];
  endfunction

  // One short, mostly well-formed run-control sequence with random content.
  task automatic random_scenario();
    int fill_count;
    case ($urandom_range(9))
      0, 1: begin
        // free run: breakpoint hits start wait episodes
        send_request($urandom_range(1) ? drcb_pkg::OP_START : drcb_pkg::OP_RESUME,
                     pick_line());
        repeat ($urandom_range(2, 8)) send_request(drcb_pkg::OP_CHECK, pick_line());
      end
      2: begin
        send_request(drcb_pkg::OP_STEP, pick_line());
        repeat ($urandom_range(1, 4)) send_request(drcb_pkg::OP_CHECK, pick_line());
      end
      3: begin
        send_request(drcb_pkg::OP_PAUSE, pick_line());
        repeat ($urandom_range(1, 5)) send_request(drcb_pkg::OP_CHECK, pick_line());
        send_request(drcb_pkg::OP_RESUME, pick_line());
      end
      4: begin
        send_request(drcb_pkg::OP_STOP, pick_line());
        repeat ($urandom_range(1, 3)) send_request(drcb_pkg::OP_CHECK, pick_line());
        send_request(drcb_pkg::OP_START, pick_line());
      end
      5, 6: repeat ($urandom_range(1, 6)) send_request(drcb_pkg::OP_TOGGLE, pick_line());
      7: begin
        // refill from empty, often past capacity
        fill_count = $urandom_range(12, POOL_SIZE);
        send_request(drcb_pkg::OP_CLEAR, pick_line());
        for (int k = 0; k < fill_count; k++) send_request(drcb_pkg::OP_TOGGLE, line_pool[k]);
      end
      8: repeat ($urandom_range(1, 6)) send_request(drcb_pkg::OP_CHECK, pick_line());
      default: repeat ($urandom_range(1, 4))
        send_request(drcb_pkg::op_t'(3'($urandom_range(7))), LW'($urandom));
    endcase
  endtask

  task automatic run_random_phase(input logic attach, input int unsigned idle_pct,
                                  input int unsigned hold_pct);
    int first;
    set_notifier(attach);
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    first         = requests_sent;
    while (requests_sent - first < PHASE_ITEMS) random_scenario();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Run modes, step consumption, wait episodes and both notices.
  task automatic test_run_control();
    send_request(drcb_pkg::OP_CHECK, 16'h0000);   // free run, empty table: proceed
    send_request(drcb_pkg::OP_TOGGLE, 16'hFFFF);  // added
    send_request(drcb_pkg::OP_CHECK, 16'hFFFF);   // hit: wait, no listener yet
    set_notifier(1'b1);
    send_request(drcb_pkg::OP_CHECK, 16'hFFFF);   // retry: episode already noticed
    send_request(drcb_pkg::OP_RESUME, 16'h0000);
    send_request(drcb_pkg::OP_CHECK, 16'hFFFF);   // pending step skips the table
    send_request(drcb_pkg::OP_CHECK, 16'hFFFF);   // new episode: pause notice
    send_request(drcb_pkg::OP_STEP, 16'h5A5A);
    send_request(drcb_pkg::OP_CHECK, 16'h1234);   // step consumed: proceed
    send_request(drcb_pkg::OP_PAUSE, 16'hA5A5);
    send_request(drcb_pkg::OP_CHECK, 16'hABCD);   // any line waits while paused
    send_request(drcb_pkg::OP_STOP, 16'h0000);
    send_request(drcb_pkg::OP_CHECK, 16'h8000);   // stop notice
    send_request(drcb_pkg::OP_START, 16'hFFFF);
    send_request(drcb_pkg::OP_CHECK, 16'h7FFF);
  endtask

  // Fill the table, overflow it, free one slot and reuse it.
  task automatic test_table_capacity();
    send_request(drcb_pkg::OP_CLEAR, 16'h0000);
    for (int k = 0; k < SLOTS; k++) send_request(drcb_pkg::OP_TOGGLE, 16'h0100 + LW'(k));
    send_request(drcb_pkg::OP_TOGGLE, 16'hFFFF);  // full: dropped
    send_request(drcb_pkg::OP_TOGGLE, 16'h0103);  // removed
    send_request(drcb_pkg::OP_TOGGLE, 16'hFFFF);  // takes the freed slot
  endtask

  task automatic test_streaming();
    run_random_phase(1'b0, 0, 0);
  endtask

  task automatic test_sparse_sender();
    run_random_phase(1'b1, 85, 0);
  endtask

  task automatic test_slow_receiver();
    run_random_phase(1'b0, 0, 85);
  endtask

  task automatic test_light_jitter();
    run_random_phase(1'b1, 9, 9);
  endtask

  initial begin
    line_pool[0] = '0;
    line_pool[1] = '1;
    for (int k = 2; k < POOL_SIZE; k++) line_pool[k] = LW'($urandom);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_run_control();
    test_table_capacity();
    test_streaming();
    test_sparse_sender();
    test_slow_receiver();
    test_light_jitter();

    drain_requests();
    stall_pct = 0;
    repeat (8) @(posedge clk);  // room for any stray response
    fail_count += answers_owed.size();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #RUN_LIMIT_NS;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
